// ===== design/fast_inverse_square_root_top_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef FAST_INVERSE_SQUARE_ROOT_TOP_MACROS_SVH
`define FAST_INVERSE_SQUARE_ROOT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define FISR_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define FISR_ASSERT_NR(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define FISR_ASSERT(name, clk, rst, prop)
`define FISR_ASSERT_NR(name, clk, prop)
`endif
`endif

// ===== design/fisr_pkg.sv =====
package fisr_pkg;

   localparam logic [31:0] MAGIC_GUESS  = 32'h5f3759df;
   localparam logic [31:0] FP_HALF      = 32'h3f000000;
   localparam logic [31:0] FP_THREE_HALF = 32'h3fc00000;
   localparam logic [31:0] FP_QNAN      = 32'h7fc00000;

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      n = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) n = 6'(47 - i);
      end
      return n;
   endfunction

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      n = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) n = 5'(26 - i);
      end
      return n;
   endfunction

endpackage

// ===== design/fisr_fmul.sv =====
module fisr_fmul import fisr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   input  logic [31:0] side,
   output logic        out_valid,
   output logic [31:0] product,
   output logic [31:0] side_out
);

   logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
   logic [7:0]  ea, eb;
   logic [23:0] ma, mb;

   logic        va_ff, sa_ff, nan_a_ff, inf_a_ff, zero_a_ff;
   logic [47:0] p_a_ff;
   logic [8:0]  esum_a_ff;
   logic [31:0] side_a_ff;

   logic        vb_ff, sb_ff, nan_b_ff, inf_b_ff, zero_b_ff;
   logic [47:0] p_b_ff;
   logic [6:0]  r_b_ff;
   logic signed [10:0] er_b_ff;
   logic [31:0] side_b_ff;

   logic [5:0]  lz;
   logic signed [10:0] er_in, r_raw;
   logic [6:0]  r_in;

   logic [95:0] ext, q, mask;
   logic        lost, g, st, inc, ovf;
   logic [7:0]  efield;
   logic [30:0] packed_bits;
   logic [31:0] res_in;

   logic        vc_ff;
   logic [31:0] res_ff, side_c_ff;

   assign a_zero = op_a[30:0] == 31'd0;
   assign b_zero = op_b[30:0] == 31'd0;
   assign a_inf  = op_a[30:23] == 8'hff && op_a[22:0] == 23'd0;
   assign b_inf  = op_b[30:23] == 8'hff && op_b[22:0] == 23'd0;
   assign a_nan  = op_a[30:23] == 8'hff && op_a[22:0] != 23'd0;
   assign b_nan  = op_b[30:23] == 8'hff && op_b[22:0] != 23'd0;
   assign ea = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
   assign eb = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
   assign ma = {op_a[30:23] != 8'd0, op_a[22:0]};
   assign mb = {op_b[30:23] != 8'd0, op_b[22:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_a_ff    <= ma * mb;
         esum_a_ff <= {1'b0, ea} + {1'b0, eb};
         sa_ff     <= op_a[31] ^ op_b[31];
         nan_a_ff  <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
         inf_a_ff  <= a_inf | b_inf;
         zero_a_ff <= a_zero | b_zero;
         side_a_ff <= side;
      end
   end

   assign lz    = lzc48(p_a_ff);
   assign er_in = $signed({2'b00, esum_a_ff}) - 11'sd126 - $signed({5'd0, lz});
   assign r_raw = (er_in >= 11'sd1) ? (11'sd48 - $signed({5'd0, lz}))
                                    : (11'sd49 - $signed({5'd0, lz}) - er_in);
   assign r_in  = (r_raw > 11'sd96) ? 7'd96 : r_raw[6:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         p_b_ff    <= p_a_ff;
         r_b_ff    <= r_in;
         er_b_ff   <= er_in;
         sb_ff     <= sa_ff;
         nan_b_ff  <= nan_a_ff;
         inf_b_ff  <= inf_a_ff;
         zero_b_ff <= zero_a_ff;
         side_b_ff <= side_a_ff;
      end
   end

   assign ext    = {p_b_ff, 48'd0};
   assign q      = ext >> r_b_ff;
   assign mask   = (r_b_ff >= 7'd96) ? {96{1'b1}} : ~({96{1'b1}} << r_b_ff);
   assign lost   = |(ext & mask);
   assign g      = q[23];
   assign st     = (|q[22:0]) | lost;
   assign inc    = g & (st | q[24]);
   assign efield = (er_b_ff >= 11'sd1) ? er_b_ff[7:0] : 8'd0;
   assign ovf    = er_b_ff >= 11'sd255;
   assign packed_bits = {efield, q[46:24]} + {30'd0, inc};

   always_comb begin
      if (nan_b_ff) begin
         res_in = FP_QNAN;
      end else if (inf_b_ff || (ovf && !zero_b_ff)) begin
         res_in = {sb_ff, 8'hff, 23'd0};
      end else if (zero_b_ff) begin
         res_in = {sb_ff, 31'd0};
      end else begin
         res_in = {sb_ff, packed_bits};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff    <= res_in;
         side_c_ff <= side_b_ff;
      end
   end

   assign out_valid = vc_ff;
   assign product   = res_ff;
   assign side_out  = side_c_ff;

endmodule

// ===== design/fisr_fadd.sv =====
module fisr_fadd import fisr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   input  logic [31:0] side,
   output logic        out_valid,
   output logic [31:0] total,
   output logic [31:0] side_out
);

   logic        a_inf, b_inf, a_nan, b_nan, swap;
   logic [31:0] bg, sm;
   logic [7:0]  eg, es, d;
   logic [26:0] sm_ext, shifted;
   logic        sm_lost;

   logic        va_ff, sg_a_ff, sub_a_ff, zs_a_ff, nan_a_ff, inf_a_ff, infs_a_ff;
   logic [26:0] big_a_ff, small_a_ff;
   logic [7:0]  eg_a_ff;
   logic [31:0] side_a_ff;

   logic [27:0] s_in;
   logic        vb_ff, sg_b_ff, zs_b_ff, nan_b_ff, inf_b_ff, infs_b_ff;
   logic [27:0] s_b_ff;
   logic [4:0]  lz_b_ff;
   logic [7:0]  eg_b_ff;
   logic [31:0] side_b_ff;

   logic [7:0]  k, emax;
   logic [26:0] mn;
   logic [8:0]  en;
   logic [7:0]  efield;
   logic        inc, ovf;
   logic [30:0] packed_bits;
   logic [31:0] res_in;

   logic        vc_ff;
   logic [31:0] res_ff, side_c_ff;

   assign a_inf = op_a[30:23] == 8'hff && op_a[22:0] == 23'd0;
   assign b_inf = op_b[30:23] == 8'hff && op_b[22:0] == 23'd0;
   assign a_nan = op_a[30:23] == 8'hff && op_a[22:0] != 23'd0;
   assign b_nan = op_b[30:23] == 8'hff && op_b[22:0] != 23'd0;
   assign swap  = op_b[30:0] > op_a[30:0];
   assign bg    = swap ? op_b : op_a;
   assign sm    = swap ? op_a : op_b;
   assign eg    = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
   assign es    = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
   assign d     = eg - es;
   assign sm_ext  = {sm[30:23] != 8'd0, sm[22:0], 3'b000};
   assign shifted = (d >= 8'd27) ? 27'd0 : (sm_ext >> d);
   assign sm_lost = (d >= 8'd27) ? (|sm_ext) : (|(sm_ext & ~({27{1'b1}} << d)));

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         big_a_ff   <= {bg[30:23] != 8'd0, bg[22:0], 3'b000};
         small_a_ff <= shifted | {26'd0, sm_lost};
         eg_a_ff    <= eg;
         sg_a_ff    <= bg[31];
         sub_a_ff   <= op_a[31] ^ op_b[31];
         zs_a_ff    <= op_a[31] & op_b[31];
         nan_a_ff   <= a_nan | b_nan | (a_inf & b_inf & (op_a[31] != op_b[31]));
         inf_a_ff   <= a_inf | b_inf;
         infs_a_ff  <= a_inf ? op_a[31] : op_b[31];
         side_a_ff  <= side;
      end
   end

   assign s_in = sub_a_ff ? ({1'b0, big_a_ff} - {1'b0, small_a_ff})
                          : ({1'b0, big_a_ff} + {1'b0, small_a_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         s_b_ff    <= s_in;
         lz_b_ff   <= lzc27(s_in[26:0]);
         eg_b_ff   <= eg_a_ff;
         sg_b_ff   <= sg_a_ff;
         zs_b_ff   <= zs_a_ff;
         nan_b_ff  <= nan_a_ff;
         inf_b_ff  <= inf_a_ff;
         infs_b_ff <= infs_a_ff;
         side_b_ff <= side_a_ff;
      end
   end

   assign emax = eg_b_ff - 8'd1;
   assign k    = ({3'd0, lz_b_ff} < emax) ? {3'd0, lz_b_ff} : emax;

   always_comb begin
      if (s_b_ff[27]) begin
         mn = {s_b_ff[27:2], s_b_ff[1] | s_b_ff[0]};
         en = {1'b0, eg_b_ff} + 9'd1;
      end else begin
         mn = s_b_ff[26:0] << k;
         en = {1'b0, eg_b_ff} - {1'b0, k};
      end
   end

   assign efield = mn[26] ? en[7:0] : 8'd0;
   assign ovf    = en >= 9'd255;
   assign inc    = mn[2] & ((|mn[1:0]) | mn[3]);
   assign packed_bits = {efield, mn[25:3]} + {30'd0, inc};

   always_comb begin
      if (nan_b_ff) begin
         res_in = FP_QNAN;
      end else if (inf_b_ff) begin
         res_in = {infs_b_ff, 8'hff, 23'd0};
      end else if (s_b_ff == 28'd0) begin
         res_in = {zs_b_ff, 31'd0};
      end else if (ovf) begin
         res_in = {sg_b_ff, 8'hff, 23'd0};
      end else begin
         res_in = {sg_b_ff, packed_bits};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff    <= res_in;
         side_c_ff <= side_b_ff;
      end
   end

   assign out_valid = vc_ff;
   assign total     = res_ff;
   assign side_out  = side_c_ff;

endmodule

// ===== design/fast_inverse_square_root_top.sv =====
// Fast inverse square root: takes one single-precision bit pattern per word on
// req_ and returns the magic-constant guess refined by one Newton step on rsp_,
// rounded to nearest-even at every operation, NaN results as 0x7FC00000.
// A word is accepted every cycle while the chain is not held; each word passes
// through four 3-stage multipliers and a 3-stage adder in a chain. When a
// result is held by rsp_tready low the whole chain holds and req_tready drops.
`include "fast_inverse_square_root_top_macros.svh"
module fast_inverse_square_root_top import fisr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // operand_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // estimate_bits
);

   logic        advance;
   logic [31:0] guess;
   logic        v1, v2, v3, v4;
   logic [31:0] half, hy, t, d, y1, y2, y3, y4;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign guess      = MAGIC_GUESS - {req_tdata[31], req_tdata[31:1]};

   fisr_fmul u_half (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(req_tvalid),
      .op_a(req_tdata), .op_b(FP_HALF), .side(guess),
      .out_valid(v1), .product(half), .side_out(y1)
   );

   fisr_fmul u_hy (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(v1),
      .op_a(half), .op_b(y1), .side(y1),
      .out_valid(v2), .product(hy), .side_out(y2)
   );

   fisr_fmul u_t (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(v2),
      .op_a(hy), .op_b(y2), .side(y2),
      .out_valid(v3), .product(t), .side_out(y3)
   );

   fisr_fadd u_diff (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(v3),
      .op_a(FP_THREE_HALF), .op_b({~t[31], t[30:0]}), .side(y3),
      .out_valid(v4), .total(d), .side_out(y4)
   );

   fisr_fmul u_out (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(v4),
      .op_a(y4), .op_b(d), .side(y4),
      .out_valid(rsp_tvalid), .product(rsp_tdata), .side_out()
   );

   `FISR_ASSERT(a_nan_canonical, clock, reset, (rsp_tvalid && rsp_tdata[30:23] == 8'hff && rsp_tdata[22:0] != 23'd0) |-> (rsp_tdata == FP_QNAN))
   `FISR_ASSERT(a_stall_only_on_held_word, clock, reset, !req_tready |-> (rsp_tvalid && !rsp_tready))
   `FISR_ASSERT_NR(a_reset_empties, clock, reset |=> !rsp_tvalid)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import fisr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'h0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   localparam int IDLE_LIMIT = 4000;
   localparam int PAUSE_AT   = 600;

   logic [31:0] operand_queue[$];
   logic [31:0] estimate_queue[$];
   int          sent_words = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          idle_cycles = 0;
   int          errors = 0;
   bit          req_taken = 1'b0;

   fast_inverse_square_root_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] fp_pack(logic s, logic [63:0] sig, int e2);
      int           k;
      int           sh;
      int           be;
      logic [127:0] w;
      logic [63:0]  m;
      logic         g;
      logic         st;
      if (sig == 64'd0) return {s, 31'd0};
      k = 0;
      for (int i = 0; i < 64; i++) if (sig[i]) k = i;
      sh = k - 23;
      if (sh < -149 - e2) sh = -149 - e2;
      if (sh <= 0) begin
         m = sig << (-sh);
         g = 1'b0;
         st = 1'b0;
      end else begin
         if (sh > 100) sh = 100;
         w = {64'd0, sig};
         m = 64'(w >> sh);
         g = w[sh-1];
         st = (w & ((128'd1 << (sh - 1)) - 128'd1)) != 128'd0;
      end
      if (g && (st || m[0])) m = m + 64'd1;
      if (m[24]) begin
         m = m >> 1;
         sh = sh + 1;
      end
      if (m[23]) begin
         be = sh + e2 + 150;
         if (be >= 255) return {s, 8'hff, 23'd0};
         return {s, be[7:0], m[22:0]};
      end
      return {s, 8'd0, m[22:0]};
   endfunction

   function automatic bit is_nan(logic [31:0] a);
      return a[30:23] == 8'hff && a[22:0] != 23'd0;
   endfunction

   function automatic bit is_inf(logic [31:0] a);
      return a[30:23] == 8'hff && a[22:0] == 23'd0;
   endfunction

   function automatic int exp2_of(logic [31:0] a);
      return (a[30:23] == 8'd0 ? 1 : int'(a[30:23])) - 150;
   endfunction

   function automatic logic [63:0] sig_of(logic [31:0] a);
      return {40'd0, a[30:23] != 8'd0, a[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      logic s;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return FP_QNAN;
      if (is_inf(a) || is_inf(b)) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return FP_QNAN;
         return {s, 8'hff, 23'd0};
      end
      return fp_pack(s, sig_of(a) * sig_of(b), exp2_of(a) + exp2_of(b));
   endfunction

   function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
      logic [31:0] t;
      logic [63:0] big;
      logic [63:0] lit;
      int          d;
      if (is_nan(a) || is_nan(b)) return FP_QNAN;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return FP_QNAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
      if (exp2_of(a) < exp2_of(b)) begin
         t = a;
         a = b;
         b = t;
      end
      d = exp2_of(a) - exp2_of(b);
      big = sig_of(a) << 39;
      if (d <= 39) lit = sig_of(b) << (39 - d);
      else lit = (sig_of(b) >> (d - 39)) |
                 64'((sig_of(b) & ((64'd1 << (d - 39)) - 64'd1)) != 64'd0);
      if (a[31] == b[31]) return fp_pack(a[31], big + lit, exp2_of(a) - 39);
      if (big == lit) return 32'd0;
      if (big > lit) return fp_pack(a[31], big - lit, exp2_of(a) - 39);
      return fp_pack(b[31], lit - big, exp2_of(a) - 39);
   endfunction

   function automatic logic [31:0] predict_estimate(logic [31:0] x);
      logic [31:0] y;
      logic [31:0] t;
      logic [31:0] r;
      y = MAGIC_GUESS - {x[31], x[31:1]};
      t = fp_mul(fp_mul(fp_mul(x, FP_HALF), y), y);
      r = fp_mul(y, fp_add(FP_THREE_HALF, {~t[31], t[30:0]}));
      return is_nan(r) ? FP_QNAN : r;
   endfunction

   function automatic int draw_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] draw_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: v[30:23] = 8'd0;
         1: v[30:23] = 8'hff;
         2: v[30:23] = 8'($urandom_range(0, 3));
         3: v[30:23] = 8'($urandom_range(252, 254));
         4: v[31] = 1'b0;
         default: ;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            estimate_queue.push_back(predict_estimate(req_tdata));
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (estimate_queue.size() == 0) begin
               $display("%0t: unexpected word, actual %08h", $time, rsp_tdata);
               errors++;
            end else begin
               if (rsp_tdata !== estimate_queue[0]) begin
                  $display("%0t: estimate_bits expected %08h actual %08h",
                           $time, estimate_queue[0], rsp_tdata);
                  errors++;
               end
               void'(estimate_queue.pop_front());
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            void'(operand_queue.pop_front());
            sent_words++;
            req_gap = ((sent_words / 200) % 2 == 1) ? 0 : draw_gap();
         end
         if (req_gap > 0 && !(req_tvalid && !req_taken)) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (operand_queue.size() != 0 &&
                      !(sent_words == PAUSE_AT && estimate_queue.size() != 0)) begin
            req_tvalid <= 1'b1;
            req_tdata <= operand_queue[0];
         end else begin
            req_tvalid <= 1'b0;
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap = ((sent_words / 300) % 2 == 1) ? 0 : draw_gap();
         end
      end
   end

   initial begin
      logic [31:0] directed[24] = '{
         32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00000,
         32'h7fa00001, 32'hffffffff, 32'h00000001, 32'h807fffff, 32'h007fffff,
         32'h00800000, 32'h3f800000, 32'h40800000, 32'h7f7fffff, 32'hff7fffff,
         32'h3e800000, 32'h5f3759df, 32'hbf800000, 32'h7effffff, 32'h00000002,
         32'h3f000000, 32'hbeef1234, 32'h55555555, 32'haaaaaaaa};
      foreach (directed[i]) operand_queue.push_back(directed[i]);
      repeat (1100) operand_queue.push_back(draw_operand());
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (operand_queue.size() == 0);
      wait (estimate_queue.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule
